// ----- rtl/core/indexed_shift_array_assert.svh -----
// Assertion macros shared by the indexed shift array RTL.
// Needs no package; each macro takes a label, clock, active-low reset, antecedent, consequent.
`ifndef INDEXED_SHIFT_ARRAY_ASSERT_SVH
`define INDEXED_SHIFT_ARRAY_ASSERT_SVH

// same-cycle implication
`define ISA_ASSERT_HOLDS(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("indexed_shift_array: assertion failed");

// next-cycle implication
`define ISA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("indexed_shift_array: assertion failed");

`endif

// ----- rtl/core/isa_pkg.sv -----
// Package for the indexed shift array: payload structs, codes, controller types.
// No dependencies.
`default_nettype none

package isa_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int ITEM_WIDTH_DEF = 32;

	localparam int CMD_W   = 3;
	localparam int IDX_W   = 7;
	localparam int ITEM_W  = 32;
	localparam int STAT_W  = 3;
	localparam int COUNT_W = 7;

	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd4;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 3'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FULL  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NULL  = 3'd4;

	// write port source
	localparam logic [1:0] WR_IN    = 2'd0;
	localparam logic [1:0] WR_SHIFT = 2'd1;
	localparam logic [1:0] WR_ITEM  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [IDX_W-1:0]  index;
		logic [ITEM_W-1:0] item;
	} isa_req_t;

	typedef struct packed {
		logic [ITEM_W-1:0]  value;
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] count;
	} isa_rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RDRESP,
		S_SHIFT,
		S_INSWR
	} isa_state_t;

	typedef struct packed {
		logic       take;
		logic       rd_en;
		logic       rd_next;
		logic       wr_en;
		logic [1:0] wr_sel;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       rsp_load;
		logic       rsp_rd;
		logic       rsp_chk;
	} isa_ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [STAT_W-1:0] chk;
		logic              no_move;
		logic              last;
		logic              up;
		logic              out_free;
	} isa_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/indexed_shift_array.sv -----
// Push, set, refused, unused: result loaded at the transfer; pop, get: loaded in S_RDRESP.
// Insert at i < n: S_SHIFT then S_INSWR; at i == n: direct write; remove below n-1: S_SHIFT.
// One command at a time: taken only when idle with the result register empty or transferring.
// Reset clears the count and result valid; storage is left uninitialised.
// Top level: controller plus datapath. Depends on isa_pkg, isa_ctrl, isa_dp.
`default_nettype none

module indexed_shift_array #(
	parameter int DEPTH      = isa_pkg::DEPTH_DEF,
	parameter int ITEM_WIDTH = isa_pkg::ITEM_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire isa_pkg::isa_req_t req_data,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output isa_pkg::isa_rsp_t      rsp_data
);

	isa_pkg::isa_ctl_t ctl;
	isa_pkg::isa_sts_t sts;

	isa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.sts      (sts),
		.req_stall(req_stall),
		.ctl      (ctl)
	);

	isa_dp #(
		.DEPTH     (DEPTH),
		.ITEM_WIDTH(ITEM_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_data),
		.ctl      (ctl),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp_data)
	);

endmodule

`default_nettype wire

// ----- rtl/core/isa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module isa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/isa_ctrl.sv -----
// Controller FSM for the indexed shift array: sequences reads, shifts and results.
// Depends on isa_pkg and indexed_shift_array_assert.svh.
`default_nettype none
`include "indexed_shift_array_assert.svh"

module isa_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire isa_pkg::isa_sts_t sts,
	output logic                  req_stall,
	output isa_pkg::isa_ctl_t     ctl
);

	isa_pkg::isa_state_t state_q, state_d;
	logic accept;

	assign req_stall = !((state_q == isa_pkg::S_IDLE) && sts.out_free);
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			isa_pkg::S_IDLE: begin
				if (accept && sts.chk == isa_pkg::STAT_OK) begin
					unique case (sts.cmd) inside
						isa_pkg::CMD_POP, isa_pkg::CMD_GET: state_d = isa_pkg::S_RDRESP;
						isa_pkg::CMD_INSERT, isa_pkg::CMD_REMOVE: begin
							if (!sts.no_move) state_d = isa_pkg::S_SHIFT;
						end
						default: state_d = isa_pkg::S_IDLE;
					endcase
				end
			end
			isa_pkg::S_RDRESP: state_d = isa_pkg::S_IDLE;
			isa_pkg::S_SHIFT: begin
				if (sts.last) state_d = sts.up ? isa_pkg::S_INSWR : isa_pkg::S_IDLE;
			end
			isa_pkg::S_INSWR: state_d = isa_pkg::S_IDLE;
			default: state_d = isa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.wr_sel = isa_pkg::WR_IN;
		unique case (state_q)
			isa_pkg::S_IDLE: begin
				if (accept) begin
					ctl.take = 1'b1;
					if (sts.chk != isa_pkg::STAT_OK) begin
						ctl.rsp_load = 1'b1;
						ctl.rsp_chk  = 1'b1;
					end else begin
						unique case (sts.cmd) inside
							isa_pkg::CMD_PUSH: begin
								ctl.wr_en    = 1'b1;
								ctl.cnt_inc  = 1'b1;
								ctl.rsp_load = 1'b1;
								ctl.rsp_chk  = 1'b1;
							end
							isa_pkg::CMD_SET: begin
								ctl.wr_en    = 1'b1;
								ctl.rsp_load = 1'b1;
								ctl.rsp_chk  = 1'b1;
							end
							isa_pkg::CMD_POP: begin
								ctl.rd_en   = 1'b1;
								ctl.cnt_dec = 1'b1;
							end
							isa_pkg::CMD_GET: ctl.rd_en = 1'b1;
							isa_pkg::CMD_INSERT: begin
								if (sts.no_move) begin
									ctl.wr_en    = 1'b1;
									ctl.cnt_inc  = 1'b1;
									ctl.rsp_load = 1'b1;
									ctl.rsp_chk  = 1'b1;
								end else begin
									ctl.rd_en = 1'b1;
								end
							end
							isa_pkg::CMD_REMOVE: begin
								if (sts.no_move) begin
									ctl.cnt_dec  = 1'b1;
									ctl.rsp_load = 1'b1;
									ctl.rsp_chk  = 1'b1;
								end else begin
									ctl.rd_en = 1'b1;
								end
							end
							default: begin
								ctl.rsp_load = 1'b1;
								ctl.rsp_chk  = 1'b1;
							end
						endcase
					end
				end
			end
			isa_pkg::S_RDRESP: begin
				ctl.rsp_load = 1'b1;
				ctl.rsp_rd   = 1'b1;
			end
			isa_pkg::S_SHIFT: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = isa_pkg::WR_SHIFT;
				if (!sts.last) begin
					ctl.rd_en   = 1'b1;
					ctl.rd_next = 1'b1;
				end else if (!sts.up) begin
					ctl.cnt_dec  = 1'b1;
					ctl.rsp_load = 1'b1;
				end
			end
			isa_pkg::S_INSWR: begin
				ctl.wr_en    = 1'b1;
				ctl.wr_sel   = isa_pkg::WR_ITEM;
				ctl.cnt_inc  = 1'b1;
				ctl.rsp_load = 1'b1;
			end
			default: ctl = '0;
		endcase
	end

	`ISA_ASSERT_HOLDS(a_busy_out_empty, clk, arst_n, state_q != isa_pkg::S_IDLE, sts.out_free)
	`ISA_ASSERT_NEXT(a_rdresp_single, clk, arst_n, state_q == isa_pkg::S_RDRESP, state_q == isa_pkg::S_IDLE)

endmodule

`default_nettype wire

// ----- rtl/core/isa_dp.sv -----
// Datapath for the indexed shift array: command checks, count, shift pointers, RAM,
// result register. Depends on isa_pkg, isa_ram and indexed_shift_array_assert.svh.
`default_nettype none
`include "indexed_shift_array_assert.svh"

module isa_dp #(
	parameter int DEPTH      = isa_pkg::DEPTH_DEF,
	parameter int ITEM_WIDTH = isa_pkg::ITEM_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire isa_pkg::isa_req_t req,
	input  wire isa_pkg::isa_ctl_t ctl,
	output isa_pkg::isa_sts_t      sts,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output isa_pkg::isa_rsp_t      rsp
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > isa_pkg::IDX_W) ? CNT_W : isa_pkg::IDX_W;

	logic [CNT_W-1:0]      count_q, count_d;
	logic [AW-1:0]         src_q, idx_q, last_addr;
	logic                  up_q, out_valid_q;
	logic [ITEM_WIDTH-1:0] item_q, item_m, rd_data, wr_data;
	logic [AW-1:0]         rd_addr, wr_addr, in_rd_addr, in_wr_addr;
	logic [CMP_W-1:0]      idx_e, n_e, in_rd_full, in_wr_full;
	logic [isa_pkg::STAT_W-1:0] chk;
	logic                  no_move;
	isa_pkg::isa_rsp_t     out_q;

	assign item_m = ITEM_WIDTH'(req.item);
	assign idx_e  = CMP_W'(req.index);
	assign n_e    = CMP_W'(count_q);

	always_comb begin
		chk = isa_pkg::STAT_OK;
		case (req.command)
			isa_pkg::CMD_PUSH: begin
				if (item_m == '0) chk = isa_pkg::STAT_NULL;
				else if (count_q == CNT_W'(DEPTH)) chk = isa_pkg::STAT_FULL;
			end
			isa_pkg::CMD_POP: begin
				if (count_q == '0) chk = isa_pkg::STAT_EMPTY;
			end
			isa_pkg::CMD_GET, isa_pkg::CMD_REMOVE: begin
				if (idx_e >= n_e) chk = isa_pkg::STAT_RANGE;
			end
			isa_pkg::CMD_SET: begin
				if (item_m == '0) chk = isa_pkg::STAT_NULL;
				else if (idx_e >= n_e) chk = isa_pkg::STAT_RANGE;
			end
			isa_pkg::CMD_INSERT: begin
				if (item_m == '0) chk = isa_pkg::STAT_NULL;
				else if (idx_e > n_e) chk = isa_pkg::STAT_RANGE;
				else if (count_q == CNT_W'(DEPTH)) chk = isa_pkg::STAT_FULL;
			end
			default: chk = isa_pkg::STAT_OK;
		endcase
	end

	always_comb begin
		case (req.command)
			isa_pkg::CMD_POP, isa_pkg::CMD_INSERT: in_rd_full = n_e - CMP_W'(1);
			isa_pkg::CMD_REMOVE: in_rd_full = idx_e + CMP_W'(1);
			default: in_rd_full = idx_e;
		endcase
	end

	assign in_wr_full = (req.command == isa_pkg::CMD_PUSH) ? n_e : idx_e;
	assign in_rd_addr = in_rd_full[AW-1:0];
	assign in_wr_addr = in_wr_full[AW-1:0];
	assign no_move    = (req.command == isa_pkg::CMD_INSERT) ? (idx_e == n_e)
	                                                        : (idx_e + CMP_W'(1) == n_e);

	assign last_addr = AW'(count_q - CNT_W'(1));

	always_comb begin
		if (ctl.rd_next) begin
			rd_addr = up_q ? (src_q - AW'(1)) : (src_q + AW'(1));
		end else begin
			rd_addr = in_rd_addr;
		end
	end

	always_comb begin
		case (ctl.wr_sel)
			isa_pkg::WR_SHIFT: begin
				wr_addr = up_q ? (src_q + AW'(1)) : (src_q - AW'(1));
				wr_data = rd_data;
			end
			isa_pkg::WR_ITEM: begin
				wr_addr = idx_q;
				wr_data = item_q;
			end
			default: begin
				wr_addr = in_wr_addr;
				wr_data = item_m;
			end
		endcase
	end

	isa_ram #(
		.WIDTH(ITEM_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ctl.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (ctl.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		if (ctl.cnt_inc) count_d = count_q + CNT_W'(1);
		else if (ctl.cnt_dec) count_d = count_q - CNT_W'(1);
		else count_d = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			up_q        <= 1'b0;
		end else begin
			count_q <= count_d;
			if (ctl.rsp_load) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
			if (ctl.take) up_q <= (req.command == isa_pkg::CMD_INSERT);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			idx_q  <= idx_e[AW-1:0];
			item_q <= item_m;
		end
		if (ctl.rd_en) src_q <= rd_addr;
		if (ctl.rsp_load) begin
			out_q.value  <= ctl.rsp_rd ? isa_pkg::ITEM_W'(rd_data) : '0;
			out_q.status <= ctl.rsp_chk ? chk : isa_pkg::STAT_OK;
			out_q.count  <= isa_pkg::COUNT_W'(count_d);
		end
	end

	assign sts.cmd      = req.command;
	assign sts.chk      = chk;
	assign sts.no_move  = no_move;
	assign sts.last     = up_q ? (src_q == idx_q) : (src_q == last_addr);
	assign sts.up       = up_q;
	assign sts.out_free = !out_valid_q || !rsp_stall;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	`ISA_ASSERT_HOLDS(a_rsp_no_overwrite, clk, arst_n, ctl.rsp_load, !out_valid_q || !rsp_stall)
	`ISA_ASSERT_HOLDS(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))
	`ISA_ASSERT_HOLDS(a_port_clash, clk, arst_n, ctl.wr_en && ctl.rd_en, wr_addr != rd_addr)

endmodule

`default_nettype wire

// ----- tb/sv/isa_checker.sv -----
// Checker for the indexed shift array: watches both channels, keeps its own copy of
// the array contents and count, predicts each result and compares it field by field.
// Depends on isa_pkg.
module isa_checker
	import isa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_stall,
	input  isa_req_t req_data,
	input  logic     rsp_valid,
	input  logic     rsp_stall,
	input  isa_rsp_t rsp_data,
	output int       errors,
	output int       pending,
	output int       held
);

	localparam int SLOTS = DEPTH_DEF;

	logic [ITEM_W-1:0] slots [0:SLOTS-1];
	int unsigned       occupancy;
	isa_rsp_t          awaited [$];

	function automatic isa_rsp_t apply_command(input isa_req_t r);
		isa_rsp_t    res;
		int unsigned n;
		int unsigned at;
		int unsigned k;
		res = '0;
		n = occupancy;
		at = 32'(r.index);
		case (r.command)
			CMD_PUSH: begin
				if (r.item == '0) res.status = STAT_NULL;
				else if (n >= SLOTS) res.status = STAT_FULL;
				else begin
					slots[n] = r.item;
					occupancy = n + 1;
				end
			end
			CMD_POP: begin
				if (n == 0) res.status = STAT_EMPTY;
				else begin
					res.value = slots[n-1];
					occupancy = n - 1;
				end
			end
			CMD_GET: begin
				if (at >= n) res.status = STAT_RANGE;
				else res.value = slots[at];
			end
			CMD_SET: begin
				if (r.item == '0) res.status = STAT_NULL;
				else if (at >= n) res.status = STAT_RANGE;
				else slots[at] = r.item;
			end
			CMD_INSERT: begin
				if (r.item == '0) res.status = STAT_NULL;
				else if (at > n) res.status = STAT_RANGE;
				else if (n >= SLOTS) res.status = STAT_FULL;
				else begin
					for (k = n; k > at; k--) slots[k] = slots[k-1];
					slots[at] = r.item;
					occupancy = n + 1;
				end
			end
			CMD_REMOVE: begin
				if (at >= n) res.status = STAT_RANGE;
				else begin
					for (k = at; k + 1 < n; k++) slots[k] = slots[k+1];
					occupancy = n - 1;
				end
			end
			default: begin
			end
		endcase
		res.count = COUNT_W'(occupancy);
		return res;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		held = 0;
		occupancy = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		isa_rsp_t want;
		if (!arst_n) begin
			occupancy = 0;
			awaited.delete();
		end else begin
			// request first: a result never leaves in the cycle its command arrives
			if (req_valid && !req_stall) awaited.push_back(apply_command(req_data));
			if (rsp_valid && !rsp_stall) begin
				if (awaited.size() == 0) begin
					$error("result with nothing awaited: %p", rsp_data);
					errors++;
				end else begin
					want = awaited.pop_front();
					if (rsp_data.value !== want.value) begin
						$error("value: expected %0h, got %0h", want.value, rsp_data.value);
						errors++;
					end
					if (rsp_data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_data.status);
						errors++;
					end
					if (rsp_data.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, rsp_data.count);
						errors++;
					end
				end
			end
		end
		pending = awaited.size();
		held = occupancy;
	end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the indexed shift array: clock, reset, command stimulus and
// result-side stalls, watchdog and verdict. Depends on isa_pkg, isa_checker and the RTL.
module tb;
	import isa_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
	localparam int RANDOM_ITEMS = 730;
	localparam int IDLE_LIMIT   = 3000;
	localparam int REQ_W        = $bits(isa_req_t);

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	isa_req_t req_data;
	logic     rsp_valid;
	logic     rsp_stall;
	isa_rsp_t rsp_data;
	int       errors;
	int       pending;
	int       held;
	int       sent;
	bit       lazy;

	indexed_shift_array dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	isa_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.errors    (errors),
		.pending   (pending),
		.held      (held)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [ITEM_W-1:0] pick_item();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 4) return '0;
		if (r < 8) return '1;
		if (r < 11) return ITEM_W'(1);
		if (r < 13) return {1'b1, {(ITEM_W-1){1'b0}}};
		return $urandom();
	endfunction

	function automatic int unsigned pick_index(input int unsigned n);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, n);
		if (r < 80) return n;
		if (r < 90) return (n > 0) ? n - 1 : 0;
		return $urandom_range(0, 127);
	endfunction

	// mode 0 grows the array, 1 shrinks it, 2 is an even mix
	function automatic logic [CMD_W-1:0] pick_command(input int mode);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r >= 96) return CMD_W'($urandom_range(0, 7));
		case (mode)
			0: begin
				if (r < 45) return CMD_PUSH;
				if (r < 80) return CMD_INSERT;
				if (r < 85) return CMD_GET;
				if (r < 90) return CMD_SET;
				if (r < 93) return CMD_POP;
				return CMD_REMOVE;
			end
			1: begin
				if (r < 40) return CMD_POP;
				if (r < 75) return CMD_REMOVE;
				if (r < 83) return CMD_GET;
				if (r < 90) return CMD_SET;
				return CMD_PUSH;
			end
			default: return CMD_W'($urandom_range(0, 5));
		endcase
	endfunction

	task automatic send(input logic [CMD_W-1:0] cmd, input int unsigned at,
			input logic [ITEM_W-1:0] word, input int unsigned gap);
		if (gap > 0) begin
			req_valid = 1'b0;
			req_data = REQ_W'({$urandom(), $urandom()});
			repeat (gap) @(negedge clk);
		end
		req_data.command = cmd;
		req_data.index = IDX_W'(at);
		req_data.item = word;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		sent++;
	endtask

	task automatic settle();
		req_valid = 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	// result-side back-pressure: free-running stretches, short stalls, the odd long one
	initial begin
		rsp_stall = 1'b0;
		forever begin
			if ($urandom_range(0, 9) < 3) begin
				rsp_stall = 1'b0;
				repeat ($urandom_range(1, 40)) @(negedge clk);
			end else begin
				rsp_stall = 1'b1;
				repeat (pick_gap() + 1) @(negedge clk);
				rsp_stall = 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
			else idle++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int mode;
		int phase_len;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		sent = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty-array corner cases, null rejection, then range checks, shifts and unused commands on a small array
		send(CMD_GET, 0, 32'h1234_5678, 0);
		send(CMD_POP, 0, '0, 0);
		send(CMD_REMOVE, 0, '0, 0);
		send(CMD_INSERT, 1, 32'h0000_0042, 0);
		send(CMD_PUSH, 0, '0, 0);
		send(CMD_INSERT, 0, '0, 0);
		send(CMD_PUSH, 0, '1, 0);
		send(CMD_SET, 5, '0, 0);
		send(CMD_INSERT, 0, 32'h8000_0000, 0);
		send(CMD_INSERT, 2, 32'h0000_0001, 0);
		send(CMD_PUSH, 127, 32'h5a5a_5a5a, 0);
		send(CMD_GET, 0, '0, 0);
		send(CMD_GET, 3, '0, 0);
		send(CMD_GET, 4, '0, 0);
		send(CMD_GET, 127, '1, 0);
		send(CMD_SET, 1, 32'ha5a5_a5a5, 0);
		send(CMD_SET, 4, 32'h0000_0007, 0);
		send(CMD_INSERT, 5, 32'h0000_0009, 0);
		send(CMD_REMOVE, 1, '0, 0);
		send(CMD_REMOVE, 3, '0, 0);
		send(CMD_SPARE_LO, 0, '1, 0);
		send(CMD_SPARE_HI, 127, 32'h0f0f_0f0f, 0);
		send(CMD_GET, 1, '0, 0);
		send(CMD_POP, 0, '0, 0);
		send(CMD_INSERT, 64, 32'h0000_0003, 0);
		settle();

		// random phases: grow, mix, then shrink or grow and mix again, until the command budget is sent
		mode = 0;
		while (sent < RANDOM_ITEMS + 25) begin
			phase_len = $urandom_range(80, 140);
			if (phase_len > RANDOM_ITEMS + 25 - sent) phase_len = RANDOM_ITEMS + 25 - sent;
			lazy = $urandom_range(0, 2) != 0;
			repeat (phase_len) begin
				logic [CMD_W-1:0] cmd;
				cmd = pick_command(mode);
				send(cmd, pick_index(held), pick_item(), lazy ? pick_gap() : 0);
			end
			if ($urandom_range(0, 1) == 0) settle();
			case (mode)
				0: mode = 2;
				2: mode = ($urandom_range(0, 1) == 0) ? 1 : 0;
				default: mode = 2;
			endcase
		end

		req_valid = 1'b0;
		wait (pending == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ----- indexed_shift_array.f -----
+incdir+rtl/core
rtl/core/isa_pkg.sv
rtl/core/isa_ram.sv
rtl/core/isa_ctrl.sv
rtl/core/isa_dp.sv
rtl/core/indexed_shift_array.sv
tb/sv/isa_checker.sv
tb/sv/tb.sv
